// ----- sv/bavg_pkg.sv -----
// ---------------------------------------------------------------------------
// bavg_pkg: shared types and constants of the block average downscaler
// Holds the pixel and flag structures that travel between the front end,
// the queue and the back end, plus the register map of the CSR port.
// ---------------------------------------------------------------------------
package bavg_pkg;

   // Width of one color channel.
   localparam int PIX_W = 8;

   // Register widths as seen on the CSR port.
   localparam int SF_W = 5;
   localparam int SIZE_W = 13;

   // Height clamp and the row counter that follows from it.
   localparam int HEIGHT_LIMIT = 4096;
   localparam int H_W = $clog2(HEIGHT_LIMIT + 1);
   localparam int ROW_W = $clog2(HEIGHT_LIMIT);

   // CSR port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 2;

   // Register indexes (byte address is four times the index).
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd2;

   // Register reset values.
   localparam logic [SF_W-1:0] SCALE_RESET = 5'd2;
   localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

   // Depth of the queue between front end and back end.
   localparam int QUEUE_DEPTH = 4;

   // Quotient bits produced by the divider, one per stage.
   localparam int DIV_STAGES = PIX_W;

   // One pixel, red in the lowest bits.
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } rgb_type;

   // Per-pixel control decided by the front end.
   typedef struct packed {
      logic first;
      logic emit;
      logic row_done;
      logic frame_done;
   } flags_type;

endpackage

// ----- sv/bavg_front.sv -----
// ---------------------------------------------------------------------------
// bavg_front: raster position tracking and pixel classification
// Accepts pixel words, follows their position in the frame and in the
// current block, drops pixels outside the last whole block, and queues the
// rest with their band column address and control flags.
// ---------------------------------------------------------------------------
module bavg_front #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_FACTOR = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic restart,
   input  logic [$clog2(MAX_FACTOR+1)-1:0] n_eff,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
   input  logic [bavg_pkg::H_W-1:0] h_eff,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: pix_red, pix_green, pix_blue.
   input  logic [3*bavg_pkg::PIX_W-1:0] req_tdata,
   input  logic push_ready,
   output logic push_valid,
   output logic [$clog2(MAX_WIDTH)-1:0] push_addr,
   output bavg_pkg::flags_type push_flags,
   output bavg_pkg::rgb_type push_pixel
);

   localparam int N_W = $clog2(MAX_FACTOR + 1);
   localparam int W_W = $clog2(MAX_WIDTH + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CIB_W = $clog2(MAX_FACTOR);
   localparam int H_W = bavg_pkg::H_W;
   localparam int ROW_W = bavg_pkg::ROW_W;
   localparam int CX_W = ((W_W > N_W) ? W_W : N_W) + 2;
   localparam int RX_W = ((H_W > N_W) ? H_W : N_W) + 2;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CIB_W-1:0] cib_ff, cib_in;
   logic [CIB_W-1:0] rib_ff, rib_in;
   logic [COL_W-1:0] bcol_ff, bcol_in;

   logic accept;
   logic in_col, in_row, last_blk, last_band;
   logic col_wrap, row_wrap, cib_wrap, rib_wrap;
   logic [CX_W-1:0] col_x, n_cx, w_cx, cib_x;
   logic [RX_W-1:0] row_x, n_rx, h_rx, rib_x;

   // The queue is the only thing that holds the input side back.
   assign req_tready = push_ready;
   assign accept = req_tvalid & req_tready;

   // Block membership: a pixel counts when its whole block fits the image.
   always_comb begin
      col_x = CX_W'(col_ff);
      n_cx = CX_W'(n_eff);
      w_cx = CX_W'(w_eff);
      cib_x = CX_W'(cib_ff);
      row_x = RX_W'(row_ff);
      n_rx = RX_W'(n_eff);
      h_rx = RX_W'(h_eff);
      rib_x = RX_W'(rib_ff);
      in_col = (col_x + n_cx - cib_x) <= w_cx;
      in_row = (row_x + n_rx - rib_x) <= h_rx;
      // The next block along the row, or the next band, would not fit.
      last_blk = (col_x + n_cx + n_cx - cib_x) > w_cx;
      last_band = (row_x + RX_W'(1) + n_rx) > h_rx;
   end

   // Wrap conditions of the position counters.
   assign col_wrap = (W_W'(col_ff) + W_W'(1)) >= w_eff;
   assign row_wrap = (H_W'(row_ff) + H_W'(1)) >= h_eff;
   assign cib_wrap = (N_W'(cib_ff) + N_W'(1)) >= n_eff;
   assign rib_wrap = (N_W'(rib_ff) + N_W'(1)) >= n_eff;

   // Queue word for a pixel that falls inside a whole block.
   always_comb begin
      push_valid = accept & in_col & in_row;
      push_addr = bcol_ff;
      push_pixel = bavg_pkg::rgb_type'(req_tdata);
      push_flags.first = (cib_ff == '0) && (rib_ff == '0);
      push_flags.emit = cib_wrap & rib_wrap;
      push_flags.row_done = last_blk;
      push_flags.frame_done = last_blk & last_band;
   end

   // Next position after an accepted pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cib_in = cib_ff;
      rib_in = rib_ff;
      bcol_in = bcol_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            cib_in = '0;
            bcol_in = '0;
            if (row_wrap) begin
               row_in = '0;
               rib_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
               rib_in = rib_wrap ? '0 : rib_ff + CIB_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            if (cib_wrap) begin
               cib_in = '0;
               bcol_in = bcol_ff + COL_W'(1);
            end else begin
               cib_in = cib_ff + CIB_W'(1);
            end
         end
      end
   end

   // Position registers; a register write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         cib_ff <= '0;
         rib_ff <= '0;
         bcol_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cib_ff <= cib_in;
         rib_ff <= rib_in;
         bcol_ff <= bcol_in;
      end
   end

endmodule

// ----- sv/bavg_queue.sv -----
// ---------------------------------------------------------------------------
// bavg_queue: short FIFO between front end and back end
// Decouples pixel classification from accumulation so that each side can
// stall on its own.
// ---------------------------------------------------------------------------
module bavg_queue #(
   parameter int DATA_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic pop_valid,
   input  logic pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = bavg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid & push_ready;
   assign do_pop = pop_valid & pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/bavg_back.sv -----
// ---------------------------------------------------------------------------
// bavg_back: band accumulation and block average division
// Keeps per-block-column channel sums in a band memory with read-modify-
// write forwarding, then divides each finished block sum by N*N in a
// pipelined restoring divider that ends in the result register.
// ---------------------------------------------------------------------------
module bavg_back #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_FACTOR = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic [$clog2(MAX_FACTOR+1)-1:0] n_eff,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [$clog2(MAX_WIDTH)+$bits(bavg_pkg::flags_type)
                 +$bits(bavg_pkg::rgb_type)-1:0] pop_data,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: avg_red, avg_green, avg_blue.
   output logic [3*bavg_pkg::PIX_W-1:0] rsp_tdata,
   // Field: row_done.
   output logic rsp_tlast,
   // Field: frame_done.
   output logic rsp_tuser
);

   localparam int PIX_W = bavg_pkg::PIX_W;
   localparam int N_W = $clog2(MAX_FACTOR + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int RGB_W = $bits(bavg_pkg::rgb_type);
   localparam int FLAG_W = $bits(bavg_pkg::flags_type);
   localparam int AREA_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int SUM_W = $clog2(255 * MAX_FACTOR * MAX_FACTOR + 1);
   localparam int DIV_W = SUM_W + PIX_W;
   localparam int STAGES = bavg_pkg::DIV_STAGES;

   logic adv;
   logic [COL_W-1:0] q_addr;
   bavg_pkg::flags_type q_flags;

   // Accumulation stage.
   logic s1_vld_ff;
   logic [COL_W-1:0] s1_addr_ff;
   bavg_pkg::flags_type s1_flags_ff;
   bavg_pkg::rgb_type s1_pix_ff;
   logic [3*SUM_W-1:0] band_mem [0:MAX_WIDTH-1];
   logic [3*SUM_W-1:0] rd_ff;
   logic acc_vld_ff;
   logic [COL_W-1:0] acc_addr_ff;
   logic [3*SUM_W-1:0] acc_sum_ff;
   logic [3*SUM_W-1:0] sum_word;
   logic [3*SUM_W-1:0] base_word;
   logic [PIX_W-1:0] pix_ch [0:2];
   logic fwd;
   logic [AREA_W-1:0] area_ff;

   // Divider stages; the last one is the result register.
   logic dv_ff [0:STAGES];
   logic dlast_ff [0:STAGES];
   logic duser_ff [0:STAGES];
   logic [SUM_W-1:0] drem_ff [0:STAGES][0:2];
   logic [PIX_W-1:0] dq_ff [0:STAGES][0:2];
   logic [SUM_W-1:0] rem_nx [1:STAGES][0:2];
   logic [PIX_W-1:0] q_nx [1:STAGES][0:2];

   // The whole back end moves when the result register can take a word.
   assign adv = !dv_ff[STAGES] || rsp_tready;
   assign pop_ready = adv;
   assign q_addr = pop_data[RGB_W+FLAG_W +: COL_W];
   assign q_flags = bavg_pkg::flags_type'(pop_data[RGB_W +: FLAG_W]);

   // Block area, static while a frame runs.
   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(n_eff) * AREA_W'(n_eff);
   end

   // Band memory: read for the word leaving the queue, write the new sum.
   always_ff @(posedge clock) begin
      if (adv && pop_valid) begin
         rd_ff <= band_mem[q_addr];
      end
      if (adv && s1_vld_ff) begin
         band_mem[s1_addr_ff] <= sum_word;
      end
   end

   // Sum update; the previous word's write is forwarded when it hit the
   // same column, since the memory read saw the old contents.
   always_comb begin
      pix_ch[0] = s1_pix_ff.red;
      pix_ch[1] = s1_pix_ff.green;
      pix_ch[2] = s1_pix_ff.blue;
      fwd = acc_vld_ff && (acc_addr_ff == s1_addr_ff);
      base_word = fwd ? acc_sum_ff : rd_ff;
      for (int c = 0; c < 3; c++) begin
         if (s1_flags_ff.first) begin
            sum_word[c*SUM_W +: SUM_W] = SUM_W'(pix_ch[c]);
         end else begin
            sum_word[c*SUM_W +: SUM_W] = base_word[c*SUM_W +: SUM_W] + SUM_W'(pix_ch[c]);
         end
      end
   end

   // Accumulation stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         acc_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= pop_valid;
         acc_vld_ff <= s1_vld_ff;
      end
   end

   // Accumulation stage payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff <= q_addr;
         s1_flags_ff <= q_flags;
         s1_pix_ff <= bavg_pkg::rgb_type'(pop_data[RGB_W-1:0]);
         acc_addr_ff <= s1_addr_ff;
         acc_sum_ff <= sum_word;
      end
   end

   // One quotient bit per stage, most significant first.
   always_comb begin
      logic [DIV_W-1:0] dsor;
      logic [DIV_W-1:0] rem_x;
      logic ge;
      for (int j = 1; j <= STAGES; j++) begin
         dsor = DIV_W'(area_ff) << (STAGES - j);
         for (int c = 0; c < 3; c++) begin
            rem_x = DIV_W'(drem_ff[j-1][c]);
            ge = rem_x >= dsor;
            rem_nx[j][c] = ge ? SUM_W'(rem_x - dsor) : drem_ff[j-1][c];
            q_nx[j][c] = dq_ff[j-1][c];
            q_nx[j][c][STAGES-j] = ge;
         end
      end
   end

   // Divider valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= STAGES; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= s1_vld_ff & s1_flags_ff.emit;
         for (int j = 1; j <= STAGES; j++) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end
   end

   // Divider payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         dlast_ff[0] <= s1_flags_ff.row_done;
         duser_ff[0] <= s1_flags_ff.frame_done;
         for (int c = 0; c < 3; c++) begin
            drem_ff[0][c] <= sum_word[c*SUM_W +: SUM_W];
            dq_ff[0][c] <= '0;
         end
         for (int j = 1; j <= STAGES; j++) begin
            dlast_ff[j] <= dlast_ff[j-1];
            duser_ff[j] <= duser_ff[j-1];
            for (int c = 0; c < 3; c++) begin
               drem_ff[j][c] <= rem_nx[j][c];
               dq_ff[j][c] <= q_nx[j][c];
            end
         end
      end
   end

   // Result word.
   assign rsp_tvalid = dv_ff[STAGES];
   assign rsp_tdata = {dq_ff[STAGES][2], dq_ff[STAGES][1], dq_ff[STAGES][0]};
   assign rsp_tlast = dlast_ff[STAGES];
   assign rsp_tuser = duser_ff[STAGES];

endmodule

// ----- sv/block_average_downscaler.sv -----
// The downscaler takes one RGB pixel word per clock in row-major order and
// sustains that rate as long as the receiver keeps up; each NxN block yields
// one averaged word, which travels through the queue, the band memory
// read-modify-write stage and the eight-stage restoring divider that
// produces one quotient bit per stage. Any register write restarts the
// frame at its first pixel; registers should be written only while no
// pixel is in flight.
// ---------------------------------------------------------------------------
// block_average_downscaler: NxN block average image downscaler
// Front end tracks raster position and classifies pixels, a short queue
// decouples it from the back end that accumulates band sums and divides
// by the block area. Configuration through an APB-style CSR port.
// ---------------------------------------------------------------------------
module block_average_downscaler #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_FACTOR = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: pix_red, pix_green, pix_blue.
   input  logic [3*bavg_pkg::PIX_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: avg_red, avg_green, avg_blue.
   output logic [3*bavg_pkg::PIX_W-1:0] rsp_tdata,
   // Field: row_done.
   output logic rsp_tlast,
   // Field: frame_done.
   output logic rsp_tuser,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [bavg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bavg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bavg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int N_W = $clog2(MAX_FACTOR + 1);
   localparam int W_W = $clog2(MAX_WIDTH + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int H_W = bavg_pkg::H_W;
   localparam int SF_W = bavg_pkg::SF_W;
   localparam int SIZE_W = bavg_pkg::SIZE_W;
   localparam int DATA_W = bavg_pkg::CSR_DATA_W;
   localparam int ENTRY_W = COL_W + $bits(bavg_pkg::flags_type) + $bits(bavg_pkg::rgb_type);

   logic [SF_W-1:0] scale_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [bavg_pkg::CSR_IDX_W-1:0] csr_idx;
   logic csr_wr;
   logic restart;
   int sf_int, w_int, h_int;
   logic [N_W-1:0] n_eff;
   logic [W_W-1:0] w_eff;
   logic [H_W-1:0] h_eff;

   logic push_valid, push_ready;
   logic [COL_W-1:0] push_addr;
   bavg_pkg::flags_type push_flags;
   bavg_pkg::rgb_type push_pixel;
   logic pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // CSR decode.
   assign csr_pready = 1'b1;
   assign csr_idx = csr_paddr[bavg_pkg::CSR_IDX_W+1:2];
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign restart = csr_wr && ((csr_idx == bavg_pkg::REG_SCALE) ||
                               (csr_idx == bavg_pkg::REG_WIDTH) ||
                               (csr_idx == bavg_pkg::REG_HEIGHT));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= bavg_pkg::SCALE_RESET;
         width_ff <= bavg_pkg::WIDTH_RESET;
         height_ff <= bavg_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            bavg_pkg::REG_SCALE: begin
               scale_ff <= csr_pwdata[SF_W-1:0];
            end
            bavg_pkg::REG_WIDTH: begin
               width_ff <= csr_pwdata[SIZE_W-1:0];
            end
            bavg_pkg::REG_HEIGHT: begin
               height_ff <= csr_pwdata[SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read data.
   always_comb begin
      case (csr_idx)
         bavg_pkg::REG_SCALE: csr_prdata = DATA_W'(scale_ff);
         bavg_pkg::REG_WIDTH: csr_prdata = DATA_W'(width_ff);
         bavg_pkg::REG_HEIGHT: csr_prdata = DATA_W'(height_ff);
         default: csr_prdata = '0;
      endcase
   end

   // Zero acts as one; values beyond the supported range are clamped.
   always_comb begin
      sf_int = int'(scale_ff);
      w_int = int'(width_ff);
      h_int = int'(height_ff);
      if (sf_int == 0) begin
         sf_int = 1;
      end else if (sf_int > MAX_FACTOR) begin
         sf_int = MAX_FACTOR;
      end
      if (w_int == 0) begin
         w_int = 1;
      end else if (w_int > MAX_WIDTH) begin
         w_int = MAX_WIDTH;
      end
      if (h_int == 0) begin
         h_int = 1;
      end else if (h_int > bavg_pkg::HEIGHT_LIMIT) begin
         h_int = bavg_pkg::HEIGHT_LIMIT;
      end
      n_eff = N_W'(sf_int);
      w_eff = W_W'(w_int);
      h_eff = H_W'(h_int);
   end

   bavg_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_FACTOR(MAX_FACTOR)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .n_eff     (n_eff),
      .w_eff     (w_eff),
      .h_eff     (h_eff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .push_ready(push_ready),
      .push_valid(push_valid),
      .push_addr (push_addr),
      .push_flags(push_flags),
      .push_pixel(push_pixel)
   );

   bavg_queue #(
      .DATA_W(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data ({push_addr, push_flags, push_pixel}),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   bavg_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_FACTOR(MAX_FACTOR)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .n_eff     (n_eff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule
